### hw/rtl/clm_pkg.sv
package clm_pkg;

  // default number of label entries in the chain
  localparam int MaxNodes = 1024;

  // field widths
  localparam int FuncW  = 2;
  localparam int NodeW  = 10;
  localparam int LabelW = 10;
  localparam int SizeW  = 11;
  localparam int CountW = 11;

  // register port
  localparam int ApbAddrW = 3;
  localparam int ApbDataW = 32;
  localparam logic RegActiveNodes = 1'b0;
  localparam logic [CountW-1:0] ActiveNodesRst = 11'd1024;

  // result status codes
  localparam logic StatusOk    = 1'b0;
  localparam logic StatusRange = 1'b1;

  // operation codes
  typedef enum logic [FuncW-1:0] {
    FUNC_INIT    = 2'd0,
    FUNC_CONNECT = 2'd1,
    FUNC_QUERY   = 2'd2
  } func_e;

  typedef struct packed {
    logic [FuncW-1:0] func;
    logic [NodeW-1:0] node_a;
    logic [NodeW-1:0] node_b;
  } in_word_t;

  typedef struct packed {
    logic [LabelW-1:0] label;
    logic [SizeW-1:0]  cluster_size;
    logic              status;
  } out_word_t;

  // controls from the sequencer to the head of the chain
  typedef struct packed {
    logic shift;
    logic clear;
    logic merge;
    logic init;
    logic connect;
  } sweep_ctl_t;

  // width for node counts and index compares
  function automatic int cnt_width(int m);
    return ($clog2(m + 1) > CountW) ? $clog2(m + 1) : CountW;
  endfunction

endpackage

### hw/rtl/clm_cell.sv
module clm_cell #(
  parameter int LW  = $clog2(clm_pkg::MaxNodes),
  parameter int Pos = 0
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          shift_i,
  input  logic [LW-1:0] d_i,
  output logic [LW-1:0] q_o
);
  import clm_pkg::*;

  logic [LW-1:0] label_q;

  // one label; reset gives the entry its own index
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      label_q <= LW'(Pos);
    end else if (shift_i) begin
      label_q <= d_i;
    end
  end

  assign q_o = label_q;

endmodule

### hw/rtl/clm_head.sv
module clm_head #(
  parameter int MAX_NODES = clm_pkg::MaxNodes
) (
  input  logic                                    clk_i,
  input  clm_pkg::sweep_ctl_t                     ctl_i,
  input  logic [clm_pkg::NodeW-1:0]               node_a_i,
  input  logic [clm_pkg::NodeW-1:0]               node_b_i,
  input  logic [clm_pkg::cnt_width(MAX_NODES)-1:0] count_i,
  input  logic [$clog2(MAX_NODES)-1:0]            idx_i,
  input  logic [$clog2(MAX_NODES)-1:0]            head_i,
  output logic [$clog2(MAX_NODES)-1:0]            tail_o,
  output logic [clm_pkg::LabelW-1:0]              label_o,
  output logic [clm_pkg::SizeW-1:0]               size_o
);
  import clm_pkg::*;

  localparam int LW = $clog2(MAX_NODES);
  localparam int NW = cnt_width(MAX_NODES);
  localparam int CW = $clog2(MAX_NODES + 1);

  logic [LW-1:0] la_q, lb_q;
  logic [CW-1:0] cnt_q;
  logic [LW-1:0] lo, hi, lab, tail;
  logic [NW-1:0] idx_x, a_x, b_x;
  logic          active, hit;

  // per-entry work on the word leaving the chain
  always_comb begin
    idx_x  = NW'(idx_i);
    a_x    = NW'(node_a_i);
    b_x    = NW'(node_b_i);
    active = idx_x < count_i;
    lo     = (la_q < lb_q) ? la_q : lb_q;
    hi     = (la_q < lb_q) ? lb_q : la_q;
    lab    = ctl_i.connect ? lo : la_q;
    if (ctl_i.merge) begin
      tail = (ctl_i.connect && active && (head_i == hi)) ? lo : head_i;
    end else begin
      tail = ctl_i.init ? idx_i : head_i;
    end
    hit = ctl_i.merge && active && (tail == lab);
  end

  // capture both end labels on the scan pass, count members on the merge pass
  always_ff @(posedge clk_i) begin
    if (ctl_i.shift && !ctl_i.merge && (idx_x == a_x)) begin
      la_q <= tail;
    end
    if (ctl_i.shift && !ctl_i.merge && (idx_x == b_x)) begin
      lb_q <= tail;
    end
    if (ctl_i.clear) begin
      cnt_q <= '0;
    end else if (ctl_i.shift && hit) begin
      cnt_q <= cnt_q + CW'(1);
    end
  end

  assign tail_o  = tail;
  assign label_o = LabelW'(lab);
  assign size_o  = SizeW'(cnt_q);

endmodule

### hw/rtl/cluster_label_merge.sv
// channel  | direction | handshake                  | word
// in       | input     | in_valid_i / in_ready_o    | in_word_i  (func, node_a, node_b)
// out      | output    | out_valid_o / out_ready_i  | out_word_o (label, cluster_size, status)
// apb      | input     | psel, penable, pwrite      | paddr, pwdata, prdata (active_nodes)
//
// an in-range word makes the label chain rotate once to
// pick up both end labels and once more to relabel and count
// an out-of-range word goes straight to the finish state and leaves the labels untouched
// reset loads every chain cell with its own index at once; no clearing pass
// a finished result waits in the finish state while the output register is full
module cluster_label_merge #(
  parameter int MAX_NODES = clm_pkg::MaxNodes
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  clm_pkg::in_word_t               in_word_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output clm_pkg::out_word_t              out_word_o,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [clm_pkg::ApbAddrW-1:0]    paddr,
  input  logic [clm_pkg::ApbDataW-1:0]    pwdata,
  output logic [clm_pkg::ApbDataW-1:0]    prdata,
  output logic                            pready
);
  import clm_pkg::*;

  localparam int LW = $clog2(MAX_NODES);
  localparam int NW = cnt_width(MAX_NODES);

  localparam logic [1:0] StIdle  = 2'd0;
  localparam logic [1:0] StScan  = 2'd1;
  localparam logic [1:0] StMerge = 2'd2;
  localparam logic [1:0] StFin   = 2'd3;

  logic [1:0]        state_q, state_d;
  logic [LW-1:0]     idx_q, idx_d;
  logic              out_valid_q, out_valid_d;
  logic              err_q, err_d;
  logic [CountW-1:0] active_q;
  in_word_t          req_q, req_d;
  out_word_t         out_q, out_d;

  logic              accept_in, bad, last, load_out;
  logic [NW-1:0]     n_eff;
  sweep_ctl_t        ctl;
  logic [LW-1:0]     chain [MAX_NODES];
  logic [LW-1:0]     tail;
  logic [LabelW-1:0] res_label;
  logic [SizeW-1:0]  res_size;

  // register port
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= ActiveNodesRst;
    end else if (psel && penable && pwrite && (paddr[ApbAddrW-1] == RegActiveNodes)) begin
      active_q <= pwdata[CountW-1:0];
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr[ApbAddrW-1] == RegActiveNodes) ? ApbDataW'(active_q) : '0;

  // effective node count and range check
  assign n_eff = (NW'(active_q) > NW'(MAX_NODES)) ? NW'(MAX_NODES) : NW'(active_q);
  assign bad   = (NW'(in_word_i.node_a) >= n_eff) ||
                 ((in_word_i.func == FUNC_CONNECT) && (NW'(in_word_i.node_b) >= n_eff));

  assign in_ready_o = (state_q == StIdle);
  assign accept_in  = in_valid_i && in_ready_o;
  assign last       = (idx_q == LW'(MAX_NODES - 1));
  assign load_out   = (state_q == StFin) && (!out_valid_q || out_ready_i);

  // sequencer
  always_comb begin
    state_d     = state_q;
    idx_d       = idx_q;
    err_d       = err_q;
    req_d       = req_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !out_ready_i;
    unique case (state_q)
      StIdle: begin
        if (accept_in) begin
          req_d   = in_word_i;
          err_d   = bad;
          state_d = bad ? StFin : StScan;
        end
      end
      StScan: begin
        idx_d = last ? '0 : idx_q + LW'(1);
        if (last) begin
          state_d = StMerge;
        end
      end
      StMerge: begin
        idx_d = last ? '0 : idx_q + LW'(1);
        if (last) begin
          state_d = StFin;
        end
      end
      StFin: begin
        if (load_out) begin
          out_valid_d = 1'b1;
          state_d     = StIdle;
          if (err_q) begin
            out_d = '{label: '0, cluster_size: '0, status: StatusRange};
          end else begin
            out_d = '{label: res_label, cluster_size: res_size, status: StatusOk};
          end
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      idx_q       <= '0;
      err_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      err_q       <= err_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q <= req_d;
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

  // chain controls
  always_comb begin
    ctl.shift   = (state_q == StScan) || (state_q == StMerge);
    ctl.clear   = accept_in;
    ctl.merge   = (state_q == StMerge);
    ctl.init    = (req_q.func == FUNC_INIT);
    ctl.connect = (req_q.func == FUNC_CONNECT);
  end

  // label chain: each cell passes its word toward the head every sweep cycle
  for (genvar k = 0; k < MAX_NODES; k++) begin : g_cell
    logic [LW-1:0] nxt;
    if (k == MAX_NODES - 1) begin : g_last
      assign nxt = tail;
    end else begin : g_mid
      assign nxt = chain[k+1];
    end
    clm_cell #(
      .LW (LW),
      .Pos(k)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .shift_i(ctl.shift),
      .d_i    (nxt),
      .q_o    (chain[k])
    );
  end

  clm_head #(
    .MAX_NODES(MAX_NODES)
  ) u_head (
    .clk_i   (clk_i),
    .ctl_i   (ctl),
    .node_a_i(req_q.node_a),
    .node_b_i(req_q.node_b),
    .count_i (n_eff),
    .idx_i   (idx_q),
    .head_i  (chain[0]),
    .tail_o  (tail),
    .label_o (res_label),
    .size_o  (res_size)
  );

  // sweep counter rests at zero between words
  a_idx_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StIdle) |-> (idx_q == '0))
    else $error("sweep counter not at zero while idle");

  // an error word carries no label or size
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_word_o.status) |->
      ((out_word_o.label == '0) && (out_word_o.cluster_size == '0)))
    else $error("error word with nonzero payload");

  // node_a always belongs to its own cluster
  a_size_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_word_o.status) |-> (out_word_o.cluster_size != '0))
    else $error("ok word with empty cluster");

  // leaving the finish state always posts a word
  a_fin_posts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == StIdle) && ($past(state_q) == StFin)) |-> out_valid_q)
    else $error("finish state left without a result word");

endmodule
